/* rtl/core/sdspi_pkg.sv */
// ----------------------------------------------------------------------------
// sdspi_pkg
// phase codes, command framing constants and the frame byte function
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_FILL   = 4'd1,
    PH_CMD0   = 4'd2,
    PH_POLL0  = 4'd3,
    PH_CMD1   = 4'd4,
    PH_POLL1  = 4'd5,
    PH_CMD16  = 4'd6,
    PH_POLL16 = 4'd7,
    PH_CMD17  = 4'd8,
    PH_POLL17 = 4'd9,
    PH_TOKEN  = 4'd10,
    PH_DATA   = 4'd11,
    PH_CRC    = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_READ = 2'd1,
    OP_RX   = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam logic [7:0] LEAD_CMD0  = 8'h40;
  localparam logic [7:0] LEAD_CMD1  = 8'h41;
  localparam logic [7:0] LEAD_CMD16 = 8'h50;
  localparam logic [7:0] LEAD_CMD17 = 8'h51;
  localparam logic [7:0] CMD_CRC    = 8'h95;
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam logic [7:0] TOKEN_BYTE = 8'hFE;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] FILL_RESET = 8'd80;
  localparam logic [2:0] FRAME_LAST = 3'd5;

  localparam logic [0:0] REG_FILL_COUNT = 1'b0;

  // byte k of the six byte command frame for a command phase
  function automatic logic [7:0] frame_byte(input phase_t ph, input logic [2:0] k,
                                            input logic [15:0] blk_size,
                                            input logic [31:0] addr);
    logic [7:0] lead;
    logic [7:0] res;
    case (ph)
      PH_CMD0:  lead = LEAD_CMD0;
      PH_CMD1:  lead = LEAD_CMD1;
      PH_CMD16: lead = LEAD_CMD16;
      default:  lead = LEAD_CMD17;
    endcase
    res = 8'h00;
    case (k)
      3'd0: res = lead;
      3'd1: res = (ph == PH_CMD17) ? addr[31:24] : 8'h00;
      3'd2: res = (ph == PH_CMD17) ? addr[23:16] : 8'h00;
      3'd3: begin
        if (ph == PH_CMD17) res = addr[15:8];
        else if (ph == PH_CMD16) res = blk_size[15:8];
        else res = 8'h00;
      end
      3'd4: begin
        if (ph == PH_CMD17) res = addr[7:0];
        else if (ph == PH_CMD16) res = blk_size[7:0];
        else res = 8'h00;
      end
      default: res = CMD_CRC;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sd_card_spi_read_controller.sv */
// ----------------------------------------------------------------------------
// sd_card_spi_read_controller
// byte stepped host side of an sd card in spi mode: init and single block read
// ----------------------------------------------------------------------------
// result: registered; valid in the cycle after the input transaction is accepted
// throughput: one input transaction per cycle, limited by the result register
// each input transaction yields exactly one result transaction
// reset: synchronous; phase idle, counters and lengths zero, fill count 80
// ----------------------------------------------------------------------------
`default_nettype none

module sd_card_spi_read_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] address,
  input  wire logic [15:0] size,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             tx_valid,
  output logic      [7:0]  tx_byte,
  output logic             select_card,
  output logic             fast_clock,
  output logic             data_valid,
  output logic      [7:0]  data_byte,
  output logic             data_last,
  output logic             done_res
);

  logic [7:0] init_fill_count;

  sdspi_pkg::phase_t phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] stored_block_length, stored_block_length_next;
  logic [31:0] read_address, read_address_next;
  logic [15:0] pending_size, pending_size_next;
  logic        select_active, select_active_next;
  logic        fast_mode, fast_mode_next;

  logic        txv, dv, last, done;
  logic [7:0]  tx, db;
  logic        accept;
  logic [15:0] count_inc;
  logic [7:0]  want;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sdspi_pkg::REG_FILL_COUNT) ? {24'h0, init_fill_count} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_fill_count <= sdspi_pkg::FILL_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == sdspi_pkg::REG_FILL_COUNT) begin
      init_fill_count <= pwdata[7:0];
    end
  end

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign count_inc = byte_count + 16'd1;
  assign want = (phase == sdspi_pkg::PH_POLL0 || phase == sdspi_pkg::PH_POLL1) ?
                sdspi_pkg::R1_IDLE : sdspi_pkg::R1_READY;

  // next state
  always_comb begin
    phase_next               = phase;
    byte_count_next          = byte_count;
    stored_block_length_next = stored_block_length;
    read_address_next        = read_address;
    pending_size_next        = pending_size;
    select_active_next       = select_active;
    fast_mode_next           = fast_mode;
    case (sdspi_pkg::opcode_t'(opcode))
      sdspi_pkg::OP_INIT: begin
        select_active_next = 1'b0;
        fast_mode_next     = 1'b0;
        phase_next         = sdspi_pkg::PH_FILL;
        byte_count_next    = 16'd1;
      end
      sdspi_pkg::OP_READ: begin
        read_address_next = address;
        pending_size_next = size;
        byte_count_next   = 16'd0;
        if (stored_block_length != size) begin
          stored_block_length_next = size;
          phase_next               = sdspi_pkg::PH_CMD16;
        end else begin
          phase_next = sdspi_pkg::PH_CMD17;
        end
      end
      sdspi_pkg::OP_RX: begin
        case (phase)
          sdspi_pkg::PH_FILL: begin
            if (byte_count < {8'h0, init_fill_count}) begin
              byte_count_next = count_inc;
            end else begin
              select_active_next = 1'b1;
              phase_next         = sdspi_pkg::PH_CMD0;
              byte_count_next    = 16'd0;
            end
          end
          sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD1,
          sdspi_pkg::PH_CMD16, sdspi_pkg::PH_CMD17: begin
            if (byte_count < {13'h0, sdspi_pkg::FRAME_LAST}) begin
              byte_count_next = count_inc;
            end else begin
              case (phase)
                sdspi_pkg::PH_CMD0:  phase_next = sdspi_pkg::PH_POLL0;
                sdspi_pkg::PH_CMD1:  phase_next = sdspi_pkg::PH_POLL1;
                sdspi_pkg::PH_CMD16: phase_next = sdspi_pkg::PH_POLL16;
                default:             phase_next = sdspi_pkg::PH_POLL17;
              endcase
            end
          end
          sdspi_pkg::PH_POLL0, sdspi_pkg::PH_POLL1,
          sdspi_pkg::PH_POLL16, sdspi_pkg::PH_POLL17: begin
            if (rx_byte == want) begin
              case (phase)
                sdspi_pkg::PH_POLL1: begin
                  fast_mode_next = 1'b1;
                  phase_next     = sdspi_pkg::PH_IDLE;
                end
                sdspi_pkg::PH_POLL17: phase_next = sdspi_pkg::PH_TOKEN;
                sdspi_pkg::PH_POLL0: begin
                  phase_next      = sdspi_pkg::PH_CMD1;
                  byte_count_next = 16'd0;
                end
                default: begin
                  phase_next      = sdspi_pkg::PH_CMD17;
                  byte_count_next = 16'd0;
                end
              endcase
            end
          end
          sdspi_pkg::PH_TOKEN: begin
            if (rx_byte == sdspi_pkg::TOKEN_BYTE) begin
              byte_count_next = 16'd0;
              phase_next = (stored_block_length == 16'd0) ? sdspi_pkg::PH_CRC :
                                                             sdspi_pkg::PH_DATA;
            end
          end
          sdspi_pkg::PH_DATA: begin
            byte_count_next = count_inc;
            if (count_inc >= stored_block_length) begin
              phase_next      = sdspi_pkg::PH_CRC;
              byte_count_next = 16'd0;
            end
          end
          sdspi_pkg::PH_CRC: begin
            if (byte_count == 16'd0) begin
              byte_count_next = 16'd1;
            end else begin
              phase_next      = sdspi_pkg::PH_IDLE;
              byte_count_next = 16'd0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    txv  = 1'b0;
    tx   = 8'h00;
    dv   = 1'b0;
    db   = 8'h00;
    last = 1'b0;
    done = 1'b0;
    case (sdspi_pkg::opcode_t'(opcode))
      sdspi_pkg::OP_INIT: begin
        txv = 1'b1;
        tx  = sdspi_pkg::IDLE_BYTE;
      end
      sdspi_pkg::OP_READ: begin
        txv = 1'b1;
        tx  = (stored_block_length != size) ? sdspi_pkg::LEAD_CMD16 : sdspi_pkg::LEAD_CMD17;
      end
      sdspi_pkg::OP_RX: begin
        case (phase)
          sdspi_pkg::PH_FILL: begin
            txv = 1'b1;
            tx  = (byte_count < {8'h0, init_fill_count}) ? sdspi_pkg::IDLE_BYTE :
                                                            sdspi_pkg::LEAD_CMD0;
          end
          sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD1,
          sdspi_pkg::PH_CMD16, sdspi_pkg::PH_CMD17: begin
            txv = 1'b1;
            if (byte_count < {13'h0, sdspi_pkg::FRAME_LAST}) begin
              tx = sdspi_pkg::frame_byte(phase, count_inc[2:0], pending_size, read_address);
            end else begin
              tx = sdspi_pkg::IDLE_BYTE;
            end
          end
          sdspi_pkg::PH_POLL0, sdspi_pkg::PH_POLL1,
          sdspi_pkg::PH_POLL16, sdspi_pkg::PH_POLL17: begin
            if (rx_byte != want) begin
              txv = 1'b1;
              tx  = sdspi_pkg::IDLE_BYTE;
            end else begin
              case (phase)
                sdspi_pkg::PH_POLL1: done = 1'b1;
                sdspi_pkg::PH_POLL17: begin
                  txv = 1'b1;
                  tx  = sdspi_pkg::IDLE_BYTE;
                end
                sdspi_pkg::PH_POLL0: begin
                  txv = 1'b1;
                  tx  = sdspi_pkg::LEAD_CMD1;
                end
                default: begin
                  txv = 1'b1;
                  tx  = sdspi_pkg::LEAD_CMD17;
                end
              endcase
            end
          end
          sdspi_pkg::PH_TOKEN: begin
            txv = 1'b1;
            tx  = sdspi_pkg::IDLE_BYTE;
          end
          sdspi_pkg::PH_DATA: begin
            dv   = 1'b1;
            db   = rx_byte;
            txv  = 1'b1;
            tx   = sdspi_pkg::IDLE_BYTE;
            last = (count_inc >= stored_block_length);
          end
          sdspi_pkg::PH_CRC: begin
            if (byte_count == 16'd0) begin
              txv = 1'b1;
              tx  = sdspi_pkg::IDLE_BYTE;
            end else begin
              done = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= sdspi_pkg::PH_IDLE;
      byte_count          <= 16'd0;
      stored_block_length <= 16'd0;
      read_address        <= 32'd0;
      pending_size        <= 16'd0;
      select_active       <= 1'b0;
      fast_mode           <= 1'b0;
    end else if (accept) begin
      phase               <= phase_next;
      byte_count          <= byte_count_next;
      stored_block_length <= stored_block_length_next;
      read_address        <= read_address_next;
      pending_size        <= pending_size_next;
      select_active       <= select_active_next;
      fast_mode           <= fast_mode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_valid    <= txv;
      tx_byte     <= tx;
      select_card <= select_active_next;
      fast_clock  <= fast_mode_next;
      data_valid  <= dv;
      data_byte   <= db;
      data_last   <= last;
      done_res    <= done;
    end
  end

  a_last_has_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_last |-> data_valid)
    else $error("data_last without data_valid");

  a_done_no_tx: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !tx_valid)
    else $error("done_res with a byte to send");

  a_data_sends_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> tx_valid && tx_byte == sdspi_pkg::IDLE_BYTE)
    else $error("block byte without a fill byte sent");

  a_fast_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(fast_mode) |-> phase == sdspi_pkg::PH_IDLE && $past(phase) == sdspi_pkg::PH_POLL1)
    else $error("fast clock selected outside init completion");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !in_ready |=> out_valid && $stable(tx_byte))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* test/sd_card_spi_read_controller_test.sv */
// ----------------------------------------------------------------------------
// sd_card_spi_read_controller_test
// self-checking testbench for the byte stepped sd card spi host controller.
// a mirror of the host state predicts the reply to every accepted command
// transaction. directed commands come first, then random card sessions over
// several fill counts and idle patterns, including one long output stall.
// ----------------------------------------------------------------------------
module sd_card_spi_read_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SESSION_ITEMS = 285;
  localparam logic [2:0] FILL_ADDR = {sdspi_pkg::REG_FILL_COUNT, 2'b00};

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_card;
    logic       fast_clock;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       done_res;
  } host_reply_t;

  class spi_host_mirror;
    sdspi_pkg::phase_t ph;
    logic [15:0] count;
    logic [15:0] blk_len;
    logic [15:0] pend_size;
    logic [31:0] rd_addr;
    logic        sel;
    logic        fast;
    logic [7:0]  fill;
    host_reply_t due_replies[$];
    int          errors;

    function new();
      ph = sdspi_pkg::PH_IDLE;
      count = '0;
      blk_len = '0;
      pend_size = '0;
      rd_addr = '0;
      sel = 1'b0;
      fast = 1'b0;
      fill = sdspi_pkg::FILL_RESET;
      errors = 0;
    endfunction

    function logic [7:0] cmd_byte(sdspi_pkg::phase_t p, int k);
      logic [47:0] frame;
      case (p)
        sdspi_pkg::PH_CMD0:  frame = {sdspi_pkg::LEAD_CMD0, 32'h0, sdspi_pkg::CMD_CRC};
        sdspi_pkg::PH_CMD1:  frame = {sdspi_pkg::LEAD_CMD1, 32'h0, sdspi_pkg::CMD_CRC};
        sdspi_pkg::PH_CMD16: frame = {sdspi_pkg::LEAD_CMD16, 16'h0, pend_size,
                                      sdspi_pkg::CMD_CRC};
        default:             frame = {sdspi_pkg::LEAD_CMD17, rd_addr, sdspi_pkg::CMD_CRC};
      endcase
      return frame[47 - 8 * k -: 8];
    endfunction

    function void take_command(sdspi_pkg::opcode_t op, logic [31:0] a, logic [15:0] s,
                               logic [7:0] rx);
      host_reply_t r;
      logic [7:0] want;
      r = '0;
      case (op)
        sdspi_pkg::OP_INIT: begin
          sel = 1'b0;
          fast = 1'b0;
          ph = sdspi_pkg::PH_FILL;
          count = 16'd1;
          r.tx_valid = 1'b1;
          r.tx_byte = sdspi_pkg::IDLE_BYTE;
        end
        sdspi_pkg::OP_READ: begin
          rd_addr = a;
          pend_size = s;
          count = '0;
          if (blk_len != s) begin
            blk_len = s;
            ph = sdspi_pkg::PH_CMD16;
          end else begin
            ph = sdspi_pkg::PH_CMD17;
          end
          r.tx_valid = 1'b1;
          r.tx_byte = cmd_byte(ph, 0);
        end
        sdspi_pkg::OP_RX: begin
          case (ph)
            sdspi_pkg::PH_FILL: begin
              r.tx_valid = 1'b1;
              if (count < {8'h00, fill}) begin
                count++;
                r.tx_byte = sdspi_pkg::IDLE_BYTE;
              end else begin
                sel = 1'b1;
                ph = sdspi_pkg::PH_CMD0;
                count = '0;
                r.tx_byte = cmd_byte(ph, 0);
              end
            end
            sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD1,
            sdspi_pkg::PH_CMD16, sdspi_pkg::PH_CMD17: begin
              r.tx_valid = 1'b1;
              if (count < 16'd5) begin
                count++;
                r.tx_byte = cmd_byte(ph, int'(count));
              end else begin
                ph = sdspi_pkg::phase_t'(ph + 4'd1);
                r.tx_byte = sdspi_pkg::IDLE_BYTE;
              end
            end
            sdspi_pkg::PH_POLL0, sdspi_pkg::PH_POLL1,
            sdspi_pkg::PH_POLL16, sdspi_pkg::PH_POLL17: begin
              want = (ph == sdspi_pkg::PH_POLL0 || ph == sdspi_pkg::PH_POLL1) ?
                     sdspi_pkg::R1_IDLE : sdspi_pkg::R1_READY;
              if (rx != want) begin
                r.tx_valid = 1'b1;
                r.tx_byte = sdspi_pkg::IDLE_BYTE;
              end else if (ph == sdspi_pkg::PH_POLL1) begin
                fast = 1'b1;
                ph = sdspi_pkg::PH_IDLE;
                r.done_res = 1'b1;
              end else if (ph == sdspi_pkg::PH_POLL17) begin
                ph = sdspi_pkg::PH_TOKEN;
                r.tx_valid = 1'b1;
                r.tx_byte = sdspi_pkg::IDLE_BYTE;
              end else begin
                ph = (ph == sdspi_pkg::PH_POLL0) ? sdspi_pkg::PH_CMD1 : sdspi_pkg::PH_CMD17;
                count = '0;
                r.tx_valid = 1'b1;
                r.tx_byte = cmd_byte(ph, 0);
              end
            end
            sdspi_pkg::PH_TOKEN: begin
              r.tx_valid = 1'b1;
              r.tx_byte = sdspi_pkg::IDLE_BYTE;
              if (rx == sdspi_pkg::TOKEN_BYTE) begin
                count = '0;
                ph = (blk_len == '0) ? sdspi_pkg::PH_CRC : sdspi_pkg::PH_DATA;
              end
            end
            sdspi_pkg::PH_DATA: begin
              r.data_valid = 1'b1;
              r.data_byte = rx;
              count++;
              r.tx_valid = 1'b1;
              r.tx_byte = sdspi_pkg::IDLE_BYTE;
              if (count >= blk_len) begin
                r.data_last = 1'b1;
                ph = sdspi_pkg::PH_CRC;
                count = '0;
              end
            end
            sdspi_pkg::PH_CRC: begin
              if (count == '0) begin
                count = 16'd1;
                r.tx_valid = 1'b1;
                r.tx_byte = sdspi_pkg::IDLE_BYTE;
              end else begin
                ph = sdspi_pkg::PH_IDLE;
                count = '0;
                r.done_res = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      r.select_card = sel;
      r.fast_clock = fast;
      due_replies.push_back(r);
    endfunction

    function void check_field(string name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void compare_reply(host_reply_t got);
      host_reply_t exp_r;
      if (due_replies.size() == 0) begin
        $error("result transaction with no expected reply");
        errors++;
        return;
      end
      exp_r = due_replies.pop_front();
      check_field("tx_valid", exp_r.tx_valid, got.tx_valid);
      check_field("tx_byte", exp_r.tx_byte, got.tx_byte);
      check_field("select_card", exp_r.select_card, got.select_card);
      check_field("fast_clock", exp_r.fast_clock, got.fast_clock);
      check_field("data_valid", exp_r.data_valid, got.data_valid);
      check_field("data_byte", exp_r.data_byte, got.data_byte);
      check_field("data_last", exp_r.data_last, got.data_last);
      check_field("done_res", exp_r.done_res, got.done_res);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [31:0] address;
  logic [15:0] size;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        select_card;
  logic        fast_clock;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic        data_last;
  logic        done_res;

  spi_host_mirror sb;
  host_reply_t    seen;
  int             send_idle_pct;
  int             recv_idle_pct;
  bit             hold_req;
  int             quiet_cycles;

  sd_card_spi_read_controller dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .address(address),
    .size(size),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tx_valid(tx_valid),
    .tx_byte(tx_byte),
    .select_card(select_card),
    .fast_clock(fast_clock),
    .data_valid(data_valid),
    .data_byte(data_byte),
    .data_last(data_last),
    .done_res(done_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen = {tx_valid, tx_byte, select_card, fast_clock, data_valid, data_byte,
              data_last, done_res};
      sb.compare_reply(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL sd_card_spi_read_controller");
      $finish;
    end
  end

  task automatic send_item(input sdspi_pkg::opcode_t op, input logic [31:0] addr,
                           input logic [15:0] len, input logic [7:0] rx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    address <= addr;
    size <= len;
    rx_byte <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_command(op, addr, len, rx);
    @(negedge clk);
  endtask

  task automatic write_fill(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FILL_ADDR;
    pwdata <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.fill = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.due_replies.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // card-like stimulus: replies mostly follow the protocol so sessions get deep
  task automatic pick_random(output sdspi_pkg::opcode_t op, output logic [31:0] a,
                             output logic [15:0] s, output logic [7:0] rx,
                             output bit counts);
    int p;
    int q;
    int abort_pm;
    a = $urandom;
    s = 16'($urandom);
    rx = 8'($urandom);
    counts = 1'b1;
    op = sdspi_pkg::OP_RX;
    if (sb.ph == sdspi_pkg::PH_IDLE) begin
      p = $urandom_range(0, 99);
      if (p < 3) begin
        op = sdspi_pkg::OP_NONE;
      end else if (p < 6) begin
        op = sdspi_pkg::OP_RX;
      end else if (!sb.fast || p < 14) begin
        op = sdspi_pkg::OP_INIT;
      end else begin
        op = sdspi_pkg::OP_READ;
      end
    end else begin
      p = $urandom_range(0, 999);
      abort_pm = (sb.ph == sdspi_pkg::PH_DATA && sb.blk_len > 16'd64) ? 40 : 8;
      if (p < 5) begin
        op = sdspi_pkg::OP_NONE;
      end else if (p < 5 + abort_pm) begin
        op = ($urandom_range(0, 1) == 0) ? sdspi_pkg::OP_INIT : sdspi_pkg::OP_READ;
      end else begin
        op = sdspi_pkg::OP_RX;
        case (sb.ph)
          sdspi_pkg::PH_POLL0, sdspi_pkg::PH_POLL1:
            if ($urandom_range(0, 2) == 0) rx = sdspi_pkg::R1_IDLE;
          sdspi_pkg::PH_POLL16, sdspi_pkg::PH_POLL17:
            if ($urandom_range(0, 2) == 0) rx = sdspi_pkg::R1_READY;
          sdspi_pkg::PH_TOKEN:
            if ($urandom_range(0, 2) == 0) rx = sdspi_pkg::TOKEN_BYTE;
          default: ;
        endcase
      end
    end
    if (op == sdspi_pkg::OP_READ) begin
      q = $urandom_range(0, 99);
      if (q < 25) begin
        s = sb.blk_len;
      end else if (q < 35) begin
        s = '0;
      end else if (q < 85) begin
        s = 16'($urandom_range(1, 12));
      end else if (q < 95) begin
        s = 16'($urandom_range(13, 64));
      end
    end
    if (op == sdspi_pkg::OP_NONE ||
        (op == sdspi_pkg::OP_RX && sb.ph == sdspi_pkg::PH_IDLE)) counts = 1'b0;
  endtask

  initial begin
    logic [7:0]         fills[6];
    sdspi_pkg::opcode_t op;
    logic [31:0]        a;
    logic [15:0]        s;
    logic [7:0]         rx;
    bit                 counts;
    int                 done_items;

    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    opcode = sdspi_pkg::OP_NONE;
    address = '0;
    size = '0;
    rx_byte = '0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 28;
    recv_idle_pct = 57;
    fills = '{sdspi_pkg::FILL_RESET, 8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 16)), 8'd5};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ignored items, read before init, zero length block, aborts
    send_item(sdspi_pkg::OP_NONE, 32'h0, 16'h0, 8'h00);
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, 8'hAA);
    send_item(sdspi_pkg::OP_READ, 32'hFFFF_FFFF, 16'h0000, 8'h00);
    for (int i = 0; i < 6; i++) begin
      send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, i[0] ? 8'hFF : 8'h00);
    end
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, 8'hFF);
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, sdspi_pkg::R1_READY);
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, 8'h00);
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, sdspi_pkg::TOKEN_BYTE);
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, 8'h12);
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, 8'h34);
    send_item(sdspi_pkg::OP_READ, 32'h0000_0000, 16'hFFFF, 8'hFF);
    send_item(sdspi_pkg::OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, 8'h55);
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, 8'hFF);
    send_item(sdspi_pkg::OP_INIT, 32'h0, 16'h0, 8'h00);
    send_item(sdspi_pkg::OP_RX, 32'h0, 16'h0, 8'h00);
    send_item(sdspi_pkg::OP_READ, 32'h1234_5678, 16'h0002, 8'h00);
    send_item(sdspi_pkg::OP_INIT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);

    for (int session = 0; session < 6; session++) begin
      wait_drained();
      case (session / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_fill(fills[session]);
      if (session == 1) hold_req = 1'b1;
      done_items = 0;
      while (done_items < SESSION_ITEMS) begin
        pick_random(op, a, s, rx, counts);
        send_item(op, a, s, rx);
        if (counts) done_items++;
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.due_replies.size() == 0) begin
      $display("PASS sd_card_spi_read_controller");
    end else begin
      $display("FAIL sd_card_spi_read_controller");
    end
    $finish;
  end

endmodule
